// ===== rtl/core/spg_pkg.sv =====
// Shared types and constants for the Sobel patch gradient block.
`default_nettype none

package spg_pkg;

	localparam int SAMPLE_W = 16;
	localparam int GRAD_W   = 19;
	localparam int POS_W    = 7;

	typedef logic [SAMPLE_W-1:0]       sample_t;
	typedef logic signed [GRAD_W-1:0]  grad_t;
	typedef logic [POS_W-1:0]          pos_t;

	// One window column: top, middle and bottom samples.
	typedef struct packed {
		sample_t top;
		sample_t mid;
		sample_t bot;
	} wcol_t;

	// Widen an unsigned sample into the signed gradient width.
	function automatic grad_t to_grad(input sample_t s);
		to_grad = grad_t'({{(GRAD_W-SAMPLE_W){1'b0}}, s});
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sobel_patch_gradient.sv =====
// Sobel 3x3 gradient unit for a square patch streamed in raster order.
//
// Input channel: sample_valid / sample_stall carry one 16-bit sample
// (8 fractional bits) and a patch_start flag that puts the sample at row 0,
// column 0 of a patch of (INNER_SIZE+2) x (INNER_SIZE+2) samples.
// Output channel: grad_valid / grad_stall carry grad_x, grad_y (signed,
// 8 fractional bits), the interior position out_row / out_col and
// last_of_patch. Border samples give no result.
// The accepted sample is registered in stage 1, then in the result register.
// Throughput: one sample per cycle while sample_stall is low; the line stores
// take one read and one write per cycle, the read being registered at the
// accepting edge. A sample is taken while a result still waits; only when the
// result register is full and grad_stall is high does sample_stall rise, and
// the whole pipe then holds.
// Reset clears the position counters, the window and the valid flags;
// line store contents are rewritten by rows 0 and 1 of every patch
// before any result reads them.
`default_nettype none

module sobel_patch_gradient #(
	parameter int INNER_SIZE = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  spg_pkg::sample_t sample,
	input  logic             patch_start,
	output logic             grad_valid,
	input  logic             grad_stall,
	output spg_pkg::grad_t   grad_x,
	output spg_pkg::grad_t   grad_y,
	output spg_pkg::pos_t    out_row,
	output spg_pkg::pos_t    out_col,
	output logic             last_of_patch
);
	import spg_pkg::*;

	localparam int   SIDE     = INNER_SIZE + 2;
	localparam int   AW       = $clog2(SIDE);
	localparam pos_t LAST_POS = pos_t'(SIDE - 1);
	localparam pos_t INNER_P  = pos_t'(INNER_SIZE);

	// Line stores: previous row (a) and the row before it (b).
	sample_t line_a [SIDE];
	sample_t line_b [SIDE];

	pos_t    row_q, col_q;
	wcol_t   left_q, center_q;

	logic    valid_s1;
	sample_t sample_s1, top_s1, mid_s1;
	pos_t    row_s1, col_s1;

	logic    adv;
	logic    accept;
	pos_t    cur_row, cur_col, nxt_row, nxt_col;
	logic    bypass;
	wcol_t   cur_w;
	logic    interior;
	grad_t   gx, gy;

	// Pipe moves whenever the result register can take a new value.
	assign adv          = !(grad_valid && grad_stall);
	assign sample_stall = !adv;
	assign accept       = sample_valid && adv;

	// Position of the incoming sample and the one after it.
	always_comb begin
		cur_row = patch_start ? '0 : row_q;
		cur_col = patch_start ? '0 : col_q;
		nxt_col = cur_col + pos_t'(1);
		nxt_row = cur_row;
		if (cur_col == LAST_POS) begin
			nxt_col = '0;
			nxt_row = (cur_row == LAST_POS) ? '0 : cur_row + pos_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			row_q <= nxt_row;
			col_q <= nxt_col;
		end
	end

	// Forward a same-cycle store write to the read port.
	assign bypass = valid_s1 && (col_s1[AW-1:0] == cur_col[AW-1:0]);

	// Read the line stores at the accepting edge; register the sample.
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			row_s1    <= cur_row;
			col_s1    <= cur_col;
			top_s1    <= bypass ? mid_s1 : line_b[cur_col[AW-1:0]];
			mid_s1    <= bypass ? sample_s1 : line_a[cur_col[AW-1:0]];
		end
	end

	// Write back the shifted column when stage 1 drains.
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			line_b[col_s1[AW-1:0]] <= mid_s1;
			line_a[col_s1[AW-1:0]] <= sample_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= sample_valid;
		end
	end

	assign cur_w = '{top: top_s1, mid: mid_s1, bot: sample_s1};

	// Advance the window by one column per drained sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			center_q <= '0;
		end else if (adv && valid_s1) begin
			left_q   <= center_q;
			center_q <= cur_w;
		end
	end

	// Sobel kernels over left, center and current columns.
	always_comb begin
		gx = (to_grad(cur_w.top) - to_grad(left_q.top))
		   + ((to_grad(cur_w.mid) - to_grad(left_q.mid)) <<< 1)
		   + (to_grad(cur_w.bot) - to_grad(left_q.bot));
		gy = (to_grad(left_q.bot) - to_grad(left_q.top))
		   + ((to_grad(center_q.bot) - to_grad(center_q.top)) <<< 1)
		   + (to_grad(cur_w.bot) - to_grad(cur_w.top));
	end

	assign interior = (row_s1 >= pos_t'(2)) && (col_s1 >= pos_t'(2));

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grad_valid <= 1'b0;
		end else if (adv) begin
			grad_valid <= valid_s1 && interior;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && interior) begin
			grad_x        <= gx;
			grad_y        <= gy;
			out_row       <= row_s1 - pos_t'(1);
			out_col       <= col_s1 - pos_t'(1);
			last_of_patch <= (row_s1 == LAST_POS) && (col_s1 == LAST_POS);
		end
	end

	// Last flag only on the final interior position.
	assert property (@(posedge clk) disable iff (!arst_n)
		(grad_valid && last_of_patch) |-> (out_row == INNER_P && out_col == INNER_P))
		else $error("last_of_patch off the final interior position");

	// Input holds only behind a full, stalled result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (grad_valid && grad_stall))
		else $error("input stalled without a blocked result");

	// A fresh result comes only from a sample in stage 1.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(grad_valid) |-> $past(valid_s1))
		else $error("result without a sample in stage 1");

	// Results lie inside the patch interior.
	assert property (@(posedge clk) disable iff (!arst_n)
		grad_valid |-> (out_row >= pos_t'(1) && out_row <= INNER_P
			&& out_col >= pos_t'(1) && out_col <= INNER_P))
		else $error("result position outside the interior");

endmodule

`default_nettype wire

// ===== verif/sobel_patch_gradient_tb.sv =====
// Self-checking testbench for the Sobel patch gradient block.
`timescale 1ns / 1ps

module sobel_patch_gradient_tb;
	import spg_pkg::*;

	localparam int INNER = 8;
	localparam int SIDE = INNER + 2;
	localparam int PATCH_LEN = SIDE * SIDE;
	localparam sample_t SAMPLE_MAX = 16'hFF00;
	localparam int RANDOM_ITEMS = 2000;
	localparam int LONG_HOLD = 300;

	// Patch content patterns
	typedef enum int {
		PAT_RANDOM, PAT_EDGE_FALL_X, PAT_EDGE_RISE_X, PAT_EDGE_FALL_Y,
		PAT_EDGE_RISE_Y, PAT_CHECKER, PAT_FLAT_MAX, PAT_RAMP
	} pattern_t;

	typedef struct packed {
		grad_t gx;
		grad_t gy;
		pos_t  row;
		pos_t  col;
		logic  is_last;
	} grad_result_t;

	// Tracks the patch position, line stores and window, and queues the gradients due
	class grad_scoreboard;
		sample_t prev_row[SIDE];
		sample_t prev_row2[SIDE];
		wcol_t win_left;
		wcol_t win_mid;
		int col_pos;
		int row_pos;
		grad_result_t pending[$];
		int errors;

		function new();
			for (int i = 0; i < SIDE; i++) begin
				prev_row[i] = '0;
				prev_row2[i] = '0;
			end
			win_left = '0;
			win_mid = '0;
			col_pos = 0;
			row_pos = 0;
			errors = 0;
		endfunction

		function void note_sample(sample_t s, logic start);
			wcol_t cur;
			int gx;
			int gy;
			grad_result_t res;
			if (start) begin
				col_pos = 0;
				row_pos = 0;
			end
			cur.top = prev_row2[col_pos];
			cur.mid = prev_row[col_pos];
			cur.bot = s;
			// Interior positions only; the window then spans three full columns
			if (row_pos >= 2 && col_pos >= 2) begin
				gx = (int'(cur.top) - int'(win_left.top))
					+ 2 * (int'(cur.mid) - int'(win_left.mid))
					+ (int'(cur.bot) - int'(win_left.bot));
				gy = (int'(win_left.bot) - int'(win_left.top))
					+ 2 * (int'(win_mid.bot) - int'(win_mid.top))
					+ (int'(cur.bot) - int'(cur.top));
				res.gx = grad_t'(gx);
				res.gy = grad_t'(gy);
				res.row = pos_t'(row_pos - 1);
				res.col = pos_t'(col_pos - 1);
				res.is_last = (row_pos - 1 == INNER) && (col_pos - 1 == INNER);
				pending.push_back(res);
			end
			// Shift the window and update the line stores
			win_left = win_mid;
			win_mid = cur;
			prev_row2[col_pos] = cur.mid;
			prev_row[col_pos] = s;
			// Advance the raster position with wrap at the patch end
			col_pos++;
			if (col_pos >= SIDE) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= SIDE)
					row_pos = 0;
			end
		endfunction

		function void check_result(grad_result_t got);
			grad_result_t exp_res;
			if (pending.size() == 0) begin
				$error("unexpected result at row %0d col %0d", got.row, got.col);
				errors++;
				return;
			end
			exp_res = pending.pop_front();
			if (got.gx !== exp_res.gx) begin
				$error("grad_x mismatch: expected %0d, got %0d", exp_res.gx, got.gx);
				errors++;
			end
			if (got.gy !== exp_res.gy) begin
				$error("grad_y mismatch: expected %0d, got %0d", exp_res.gy, got.gy);
				errors++;
			end
			if (got.row !== exp_res.row) begin
				$error("out_row mismatch: expected %0d, got %0d", exp_res.row, got.row);
				errors++;
			end
			if (got.col !== exp_res.col) begin
				$error("out_col mismatch: expected %0d, got %0d", exp_res.col, got.col);
				errors++;
			end
			if (got.is_last !== exp_res.is_last) begin
				$error("last_of_patch mismatch: expected %0d, got %0d",
					exp_res.is_last, got.is_last);
				errors++;
			end
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    sample_valid;
	logic    sample_stall;
	sample_t sample;
	logic    patch_start;
	logic    grad_valid;
	logic    grad_stall;
	grad_t   grad_x;
	grad_t   grad_y;
	pos_t    out_row;
	pos_t    out_col;
	logic    last_of_patch;

	grad_scoreboard sb;
	int  samples_sent;
	bit  send_burst;
	bit  hold_req;

	sobel_patch_gradient #(.INNER_SIZE(INNER)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.sample        (sample),
		.patch_start   (patch_start),
		.grad_valid    (grad_valid),
		.grad_stall    (grad_stall),
		.grad_x        (grad_x),
		.grad_y        (grad_y),
		.out_row       (out_row),
		.out_col       (out_col),
		.last_of_patch (last_of_patch)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Offer one sample after a random gap and hold it until the transfer
	task automatic push_sample(input sample_t s, input logic start);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 14);
		@(negedge clk);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		patch_start <= start;
		do @(posedge clk); while (sample_stall);
		sb.note_sample(s, start);
		samples_sent++;
	endtask

	function automatic sample_t patch_value(pattern_t pat, int r, int c);
		case (pat)
			PAT_RANDOM: return sample_t'($urandom_range(0, SAMPLE_MAX));
			PAT_EDGE_FALL_X: return (c < SIDE / 2) ? SAMPLE_MAX : '0;
			PAT_EDGE_RISE_X: return (c < SIDE / 2) ? '0 : SAMPLE_MAX;
			PAT_EDGE_FALL_Y: return (r < SIDE / 2) ? SAMPLE_MAX : '0;
			PAT_EDGE_RISE_Y: return (r < SIDE / 2) ? '0 : SAMPLE_MAX;
			PAT_CHECKER: return ((r + c) % 2 == 0) ? SAMPLE_MAX : '0;
			PAT_FLAT_MAX: return SAMPLE_MAX;
			default: return sample_t'((r * 300 + c * 200 + $urandom_range(0, 255)) & 16'hFFFF);
		endcase
	endfunction

	// Stream a patch in raster order, cut short after stop_at samples
	task automatic send_patch(input pattern_t pat, input bit use_start, input int stop_at);
		int n;
		n = 0;
		for (int r = 0; r < SIDE; r++) begin
			for (int c = 0; c < SIDE; c++) begin
				if (n < stop_at)
					push_sample(patch_value(pat, r, c), use_start && n == 0);
				n++;
			end
		end
	endtask

	// Result side: random stalls, one long hold-off on request
	initial begin
		int gap;
		bit recv_burst;
		grad_result_t got;
		recv_burst = 1'b0;
		grad_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				gap = LONG_HOLD;
			end else begin
				if ($urandom_range(0, 39) == 0)
					recv_burst = ~recv_burst;
				gap = recv_burst ? 0 : $urandom_range(0, 14);
			end
			if (gap > 0) begin
				grad_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			grad_stall <= 1'b0;
			do @(posedge clk); while (!grad_valid);
			got.gx = grad_x;
			got.gy = grad_y;
			got.row = out_row;
			got.col = out_col;
			got.is_last = last_of_patch;
			sb.check_result(got);
		end
	end

	// Stimulus and end of run
	initial begin
		int choice;
		bit prev_done;
		int pressure_at;
		sb = new();
		samples_sent = 0;
		send_burst = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		patch_start = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, restart in the middle of a row, back-to-back restarts
		push_sample(SAMPLE_MAX, 1'b1);
		push_sample('0, 1'b0);
		push_sample(16'h00FF, 1'b0);
		push_sample(SAMPLE_MAX, 1'b0);
		push_sample(16'h5A5A, 1'b0);
		push_sample(16'hA5A5 & SAMPLE_MAX, 1'b0);
		push_sample(16'h0001, 1'b1);
		push_sample(SAMPLE_MAX, 1'b1);
		for (int i = 0; i < 12; i++)
			push_sample((i % 2) ? SAMPLE_MAX : '0, 1'b0);
		push_sample('0, 1'b1);

		// Random: mostly whole patches, with broken patches and noise mixed in
		prev_done = 1'b0;
		pressure_at = 600 + samples_sent;
		samples_sent = 0;
		while (samples_sent < RANDOM_ITEMS) begin
			send_burst = ($urandom_range(0, 2) == 0);
			if (samples_sent >= 600 && pressure_at > 0) begin
				pressure_at = 0;
				hold_req = 1'b1;
				send_burst = 1'b1;
			end
			choice = $urandom_range(0, 9);
			if (choice == 0) begin
				repeat ($urandom_range(1, 30))
					push_sample(sample_t'($urandom_range(0, SAMPLE_MAX)),
						$urandom_range(0, 7) == 0);
				prev_done = 1'b0;
			end else if (choice == 1) begin
				send_patch(pattern_t'($urandom_range(0, 7)), 1'b1,
					$urandom_range(1, PATCH_LEN - 1));
				prev_done = 1'b0;
			end else begin
				send_patch(pattern_t'($urandom_range(0, 7)),
					prev_done ? bit'($urandom_range(0, 1)) : 1'b1, PATCH_LEN);
				prev_done = 1'b1;
			end
		end
		@(negedge clk);
		sample_valid <= 1'b0;

		// Drain, then watch for stray results
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/spg_pkg.sv
rtl/core/sobel_patch_gradient.sv
verif/sobel_patch_gradient_tb.sv
